FILE: design/go_to_pose_controller_assert.svh
// Assertion macros for the go-to-pose controller.
// Each macro expects clk and rst_n in scope.
`ifndef GO_TO_POSE_CONTROLLER_ASSERT_SVH
`define GO_TO_POSE_CONTROLLER_ASSERT_SVH

`define GTP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define GTP_ASSERT_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

FILE: design/gtp_pkg.sv
`default_nettype none
package gtp_pkg;

  localparam int CORDIC_ITER_DEF = 16;
  localparam int CORDIC_ITER_MAX = 32;

  // CORDIC datapath widths
  localparam int IN_W      = 35;
  localparam int CW        = 45;
  localparam int ANG_W     = 20;
  localparam int MAG_W     = 44;
  localparam int K_W       = 6;
  localparam int NORM_BITS = 41;
  localparam int GAIN_W    = 20;
  localparam int THR_W     = 31;
  localparam int HDG_W     = 19;

  localparam logic signed [ANG_W-1:0] PI_Q16       = 20'sd205887;
  localparam logic [GAIN_W-1:0]       INV_GAIN_Q20 = 20'd636751;
  localparam logic signed [IN_W-1:0]  QUAT_ONE_SQ  = 35'sd268435456;

  // configuration register indexes
  localparam logic [2:0] REG_TARGET_X   = 3'd0;
  localparam logic [2:0] REG_TARGET_Y   = 3'd1;
  localparam logic [2:0] REG_TARGET_HDG = 3'd2;
  localparam logic [2:0] REG_THRESHOLD  = 3'd3;
  localparam logic [2:0] REG_TURN_SPD   = 3'd4;
  localparam logic [2:0] REG_FWD_SPD    = 3'd5;

  localparam logic signed [31:0]       RST_TARGET_X   = 32'sd327680;
  localparam logic signed [31:0]       RST_TARGET_Y   = -32'sd393216;
  localparam logic signed [HDG_W-1:0]  RST_TARGET_HDG = -19'sd102943;
  localparam logic [THR_W-1:0]         RST_THRESHOLD  = 31'd13107;
  localparam logic signed [31:0]       RST_TURN_SPD   = 32'sd9830;
  localparam logic signed [31:0]       RST_FWD_SPD    = 32'sd32768;

  // phase codes
  localparam logic [1:0] PH_ROTATE = 2'd0;
  localparam logic [1:0] PH_DRIVE  = 2'd1;
  localparam logic [1:0] PH_ALIGN  = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_t;

  typedef struct packed {
    logic signed [31:0] linear_cmd;
    logic signed [31:0] angular_cmd;
    logic [1:0]         phase;
  } out_t;

  // arctangent of 2^-i, Q4.16 radians
  function automatic logic signed [ANG_W-1:0] gtp_atan(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 20'sd51472;
      5'd1:    v = 20'sd30386;
      5'd2:    v = 20'sd16055;
      5'd3:    v = 20'sd8150;
      5'd4:    v = 20'sd4091;
      5'd5:    v = 20'sd2047;
      5'd6:    v = 20'sd1024;
      5'd7:    v = 20'sd512;
      5'd8:    v = 20'sd256;
      5'd9:    v = 20'sd128;
      5'd10:   v = 20'sd64;
      5'd11:   v = 20'sd32;
      5'd12:   v = 20'sd16;
      5'd13:   v = 20'sd8;
      5'd14:   v = 20'sd4;
      5'd15:   v = 20'sd2;
      5'd16:   v = 20'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: design/gtp_cordic.sv
`default_nettype none
module gtp_cordic import gtp_pkg::*; #(
  parameter int ITERS = CORDIC_ITER_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_i,
  input  logic signed [IN_W-1:0]  x_i,
  input  logic signed [IN_W-1:0]  y_i,
  output logic                    valid_o,
  output logic signed [ANG_W-1:0] angle_o,
  output logic [MAG_W-1:0]        mag_o
);

  localparam int LAST  = 6 + ITERS;
  localparam int XC_W  = CW - 1;
  localparam int LO_W  = XC_W / 2;
  localparam int HI_W  = XC_W - LO_W;
  localparam int PH_W  = HI_W + GAIN_W;
  localparam int PL_W  = LO_W + GAIN_W;

  // pre stage: zero check and left half-plane fold
  logic                    pv_r, pzero_r;
  logic signed [CW-1:0]    px_r, py_r;
  logic signed [ANG_W-1:0] pz_r;
  logic signed [CW-1:0]    xe, ye, px_nxt, py_nxt;
  logic signed [ANG_W-1:0] pz_nxt;

  always_comb begin
    xe = CW'(x_i);
    ye = CW'(y_i);
    if (x_i[IN_W-1]) begin
      px_nxt = -xe;
      py_nxt = -ye;
      pz_nxt = y_i[IN_W-1] ? -PI_Q16 : PI_Q16;
    end else begin
      px_nxt = xe;
      py_nxt = ye;
      pz_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    pz_r    <= pz_nxt;
    pzero_r <= (x_i == '0) && (y_i == '0);
  end

  // stage chain: index 0 after max stage, 1..6 normalize, 7..LAST micro-rotations
  logic                    sv_r    [0:LAST];
  logic                    szero_r [0:LAST];
  logic signed [CW-1:0]    sx_r    [0:LAST];
  logic signed [CW-1:0]    sy_r    [0:LAST];
  logic signed [ANG_W-1:0] sz_r    [0:LAST];
  logic [K_W-1:0]          sk_r    [0:LAST];
  logic [CW-1:0]           sm_r    [0:6];
  logic [CW-1:0]           ay_c, m_nxt;

  always_comb begin
    ay_c  = py_r[CW-1] ? $unsigned(-py_r) : $unsigned(py_r);
    m_nxt = ($unsigned(px_r) > ay_c) ? $unsigned(px_r) : ay_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else begin
      sv_r[0] <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    sx_r[0]    <= px_r;
    sy_r[0]    <= py_r;
    sz_r[0]    <= pz_r;
    sk_r[0]    <= '0;
    sm_r[0]    <= m_nxt;
    szero_r[0] <= pzero_r;
  end

  // normalize: greedy shifts by 32, 16, ..., 1 until the larger part reaches 2^40
  for (genvar j = 0; j < 6; j++) begin : g_norm
    localparam int SH = 32 >> j;
    logic do_sh;
    assign do_sh = (sm_r[j] >> (NORM_BITS - SH)) == '0;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[j+1] <= 1'b0;
      end else begin
        sv_r[j+1] <= sv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      sx_r[j+1]    <= do_sh ? (sx_r[j] <<< SH) : sx_r[j];
      sy_r[j+1]    <= do_sh ? (sy_r[j] <<< SH) : sy_r[j];
      sm_r[j+1]    <= do_sh ? (sm_r[j] << SH) : sm_r[j];
      sk_r[j+1]    <= sk_r[j] + (do_sh ? K_W'(SH) : K_W'(0));
      sz_r[j+1]    <= sz_r[j];
      szero_r[j+1] <= szero_r[j];
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    localparam int S = 6 + i;
    logic signed [CW-1:0]    xs, ys;
    logic signed [ANG_W-1:0] at;
    logic                    ypos;
    assign xs   = sx_r[S] >>> i;
    assign ys   = sy_r[S] >>> i;
    assign at   = gtp_atan(5'(i));
    assign ypos = !sy_r[S][CW-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[S+1] <= 1'b0;
      end else begin
        sv_r[S+1] <= sv_r[S];
      end
    end

    always_ff @(posedge clk) begin
      sx_r[S+1]    <= ypos ? (sx_r[S] + ys) : (sx_r[S] - ys);
      sy_r[S+1]    <= ypos ? (sy_r[S] - xs) : (sy_r[S] + xs);
      sz_r[S+1]    <= ypos ? (sz_r[S] + at) : (sz_r[S] - at);
      sk_r[S+1]    <= sk_r[S];
      szero_r[S+1] <= szero_r[S];
    end
  end

  // magnitude: split x times 1/K, round, shift back by 20 + k
  logic [XC_W-1:0]         xc;
  logic signed [ANG_W-1:0] zc;
  logic                    m1_v_r, m1_zero_r;
  logic [PH_W-1:0]         m1_ph_r;
  logic [PL_W-1:0]         m1_pl_r;
  logic [63:0]             m1_rnd_r;
  logic [K_W-1:0]          m1_k_r;
  logic signed [ANG_W-1:0] m1_z_r;

  always_comb begin
    xc = sx_r[LAST][CW-1] ? '0 : sx_r[LAST][XC_W-1:0];
    if (sz_r[LAST] > PI_Q16) begin
      zc = PI_Q16;
    end else if (sz_r[LAST] < -PI_Q16) begin
      zc = -PI_Q16;
    end else begin
      zc = sz_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else begin
      m1_v_r <= sv_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    m1_ph_r   <= PH_W'(xc[XC_W-1:LO_W]) * PH_W'(INV_GAIN_Q20);
    m1_pl_r   <= PL_W'(xc[LO_W-1:0]) * PL_W'(INV_GAIN_Q20);
    m1_rnd_r  <= 64'd1 << (7'd19 + 7'(sk_r[LAST]));
    m1_k_r    <= sk_r[LAST];
    m1_z_r    <= zc;
    m1_zero_r <= szero_r[LAST];
  end

  logic                    m2_v_r, m2_zero_r;
  logic [63:0]             m2_p_r;
  logic [K_W-1:0]          m2_k_r;
  logic signed [ANG_W-1:0] m2_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    m2_p_r    <= (64'(m1_ph_r) << LO_W) + 64'(m1_pl_r) + m1_rnd_r;
    m2_k_r    <= m1_k_r;
    m2_z_r    <= m1_z_r;
    m2_zero_r <= m1_zero_r;
  end

  logic                    m3_v_r;
  logic signed [ANG_W-1:0] m3_ang_r;
  logic [MAG_W-1:0]        m3_mag_r;
  logic [63:0]             p_sh;

  assign p_sh = m2_p_r >> (7'd20 + 7'(m2_k_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_v_r <= 1'b0;
    end else begin
      m3_v_r <= m2_v_r;
    end
  end

  // zero vector: angle and magnitude both zero
  always_ff @(posedge clk) begin
    m3_ang_r <= m2_zero_r ? '0 : m2_z_r;
    m3_mag_r <= m2_zero_r ? '0 : p_sh[MAG_W-1:0];
  end

  assign valid_o = m3_v_r;
  assign angle_o = m3_ang_r;
  assign mag_o   = m3_mag_r;

endmodule
`default_nettype wire

FILE: design/go_to_pose_controller.sv
`default_nettype none
// Channel   Ports                                     Handshake
// input     start, busy, in_data                      start high, busy low
// result    out_valid, out_data                       one-cycle strobe
// config    cfg_valid, cfg_ready, cfg_index, cfg_data valid and ready
//
// One pose item is taken every cycle; busy is high only during reset.
// The result strobes after the input stages A and B, the CORDIC pre, max and
// normalize stages, one stage per micro-rotation (iterations capped at 32),
// the magnitude stages and the decision register. Reset clears the valid
// bits and restores the register defaults. Results cannot be held off, so
// the pipeline never stalls.
module go_to_pose_controller import gtp_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  output logic        out_valid,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NUM_ITER = (CORDIC_ITERATIONS > CORDIC_ITER_MAX) ?
                            CORDIC_ITER_MAX : CORDIC_ITERATIONS;
  localparam int LAT      = 14 + NUM_ITER;

  logic in_fire;
  assign busy      = !rst_n;
  assign in_fire   = start && !busy;
  assign cfg_ready = 1'b1;

  // configuration registers
  logic signed [31:0]      tx_r, ty_r, ts_r, fs_r;
  logic signed [HDG_W-1:0] hd_r;
  logic [THR_W-1:0]        thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r  <= RST_TARGET_X;
      ty_r  <= RST_TARGET_Y;
      hd_r  <= RST_TARGET_HDG;
      thr_r <= RST_THRESHOLD;
      ts_r  <= RST_TURN_SPD;
      fs_r  <= RST_FWD_SPD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TARGET_X:   tx_r  <= cfg_data;
        REG_TARGET_Y:   ty_r  <= cfg_data;
        REG_TARGET_HDG: hd_r  <= cfg_data[HDG_W-1:0];
        REG_THRESHOLD:  thr_r <= cfg_data[THR_W-1:0];
        REG_TURN_SPD:   ts_r  <= cfg_data;
        REG_FWD_SPD:    fs_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage A: quaternion products and offset to target
  logic               a_v_r;
  logic signed [31:0] a_p1_r, a_p2_r, a_p3_r, a_p4_r;
  logic signed [32:0] a_dx_r, a_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    a_p1_r <= 32'(in_data.quat_w) * 32'(in_data.quat_z);
    a_p2_r <= 32'(in_data.quat_x) * 32'(in_data.quat_y);
    a_p3_r <= 32'(in_data.quat_y) * 32'(in_data.quat_y);
    a_p4_r <= 32'(in_data.quat_z) * 32'(in_data.quat_z);
    a_dx_r <= 33'(tx_r) - 33'(in_data.pose_x);
    a_dy_r <= 33'(ty_r) - 33'(in_data.pose_y);
  end

  // stage B: yaw vector in Q2.28
  logic                   b_v_r;
  logic signed [IN_W-1:0] b_num_r, b_den_r, b_dx_r, b_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b_num_r <= (IN_W'(a_p1_r) + IN_W'(a_p2_r)) <<< 1;
    b_den_r <= QUAT_ONE_SQ - ((IN_W'(a_p3_r) + IN_W'(a_p4_r)) <<< 1);
    b_dx_r  <= IN_W'(a_dx_r);
    b_dy_r  <= IN_W'(a_dy_r);
  end

  logic signed [ANG_W-1:0] yaw, bearing;
  logic [MAG_W-1:0]        goal_dist;
  logic                    c_v;

  gtp_cordic #(.ITERS(NUM_ITER)) u_yaw (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (b_v_r),
    .x_i     (b_den_r),
    .y_i     (b_num_r),
    .valid_o (),
    .angle_o (yaw),
    .mag_o   ()
  );

  gtp_cordic #(.ITERS(NUM_ITER)) u_goal (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (b_v_r),
    .x_i     (b_dx_r),
    .y_i     (b_dy_r),
    .valid_o (c_v),
    .angle_o (bearing),
    .mag_o   (goal_dist)
  );

  // decision
  logic signed [ANG_W:0] e_hdg, e_brg;
  logic [ANG_W:0]        ae_hdg, ae_brg;
  out_t                  out_nxt;

  always_comb begin
    e_hdg  = (ANG_W+1)'(yaw) - (ANG_W+1)'(hd_r);
    e_brg  = (ANG_W+1)'(yaw) - (ANG_W+1)'(bearing);
    ae_hdg = e_hdg[ANG_W] ? $unsigned(-e_hdg) : $unsigned(e_hdg);
    ae_brg = e_brg[ANG_W] ? $unsigned(-e_brg) : $unsigned(e_brg);
    out_nxt.linear_cmd  = '0;
    out_nxt.angular_cmd = '0;
    if (goal_dist < MAG_W'(thr_r)) begin
      if (THR_W'(ae_hdg) > thr_r) begin
        out_nxt.phase       = PH_ALIGN;
        out_nxt.angular_cmd = ts_r;
      end else begin
        out_nxt.phase = PH_DONE;
      end
    end else if (THR_W'(ae_brg) < thr_r) begin
      out_nxt.phase      = PH_DRIVE;
      out_nxt.linear_cmd = fs_r;
    end else begin
      out_nxt.phase       = PH_ROTATE;
      out_nxt.angular_cmd = ts_r;
    end
  end

  logic out_valid_r;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "go_to_pose_controller_assert.svh"

  `GTP_ASSERT_ALWAYS(a_latency, out_valid == $past(in_fire, LAT), "result strobe out of step")
  `GTP_ASSERT_IMPLIES(a_done_idle, out_valid && out_data.phase == PH_DONE, out_data.linear_cmd == '0 && out_data.angular_cmd == '0, "done phase with motion")
  `GTP_ASSERT_IMPLIES(a_drive_straight, out_valid && out_data.phase == PH_DRIVE, out_data.angular_cmd == '0, "turning while driving")
  `GTP_ASSERT_IMPLIES(a_turn_still, out_valid && (out_data.phase == PH_ROTATE || out_data.phase == PH_ALIGN), out_data.linear_cmd == '0, "moving while turning")

endmodule
`default_nettype wire
